/* rtl/rta_pkg.sv */
// Shared constants and operation codes for the route table with aging.
package rta_pkg;

	// Default table geometry.
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ADDR_BITS_DEF   = 16;

	// Fixed field widths of the item and result beats and of the lifetime register.
	localparam int OP_W     = 2;
	localparam int FIELD_W  = 16;
	localparam int LIFE_W   = 8;
	localparam int COUNT_W  = 7;

	// Lifetime register value after reset.
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd10;

	// Operation codes carried in the op field.
	localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

endpackage

/* rtl/route_table_with_aging.sv */
// Route table with learning, lookup and lifetime aging, walked one entry per cycle.
//
// Usage: an item beat (op, dest_addr, hop_addr) is taken when in_valid is high and
// in_stall is low. Op learn stores or refreshes a route, op lookup returns the next
// hop, op tick ages every entry and removes the ones whose lifetime runs out. Every
// item yields exactly one result beat (hit, next_hop, dropped, entry_count) on the
// out channel, taken when out_valid is high and out_stall is low.
// Each item walks the whole table through the single read port of the entry memory,
// one entry per cycle; the block takes no new item until it has finished the last one.
// The result beat is loaded in the final step, once the output register is free.
// The lifetime register is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. Reset empties
// the table (the valid bits clear at once, no sweep is needed) and loads a lifetime of
// 10. While out_stall holds a result, the block still takes the next item and walks
// the table, then waits in its final step until the output register is free.
module route_table_with_aging #(
	parameter int TABLE_DEPTH = rta_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_BITS   = rta_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Lifetime register write port.
	input  logic                         cfg_we,
	input  logic [rta_pkg::LIFE_W-1:0]   cfg_wdata,
	// Item channel.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rta_pkg::OP_W-1:0]     op,
	input  logic [rta_pkg::FIELD_W-1:0]  dest_addr,
	input  logic [rta_pkg::FIELD_W-1:0]  hop_addr,
	// Result channel.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [rta_pkg::FIELD_W-1:0]  next_hop,
	output logic                         dropped,
	output logic [rta_pkg::COUNT_W-1:0]  entry_count
);

	// Stored address width: the lesser of ADDR_BITS and the 16-bit field width.
	localparam int KW  = (ADDR_BITS < rta_pkg::FIELD_W) ? ADDR_BITS : rta_pkg::FIELD_W;
	localparam int LW  = rta_pkg::LIFE_W;
	localparam int EW  = 2 * KW + LW;
	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int CWX = (CW > rta_pkg::COUNT_W) ? CW : rta_pkg::COUNT_W;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]             state_q;
	logic [LW-1:0]          lifetime_q;
	logic [LW-1:0]          load_life;

	// Latched item.
	logic [rta_pkg::OP_W-1:0] op_q;
	logic [KW-1:0]          key_q;
	logic [KW-1:0]          hop_in_q;

	// Table: valid bits in flip-flops, entry words in a memory.
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [CW-1:0]          count_q;
	logic [EW-1:0]          tbl_mem_q [TABLE_DEPTH];
	logic [EW-1:0]          rd_word_q;

	// Walk pointer and the compare stage behind the memory read.
	logic [IW-1:0]          idx_q;
	logic                   chk_vld_s1;
	logic [IW-1:0]          chk_idx_s1;

	// Scan results.
	logic                   found_q;
	logic [IW-1:0]          found_idx_q;
	logic [KW-1:0]          found_hop_q;
	logic                   free_q;
	logic [IW-1:0]          free_idx_q;

	// Output register.
	logic                   out_valid_q;
	logic                   hit_q;
	logic [rta_pkg::FIELD_W-1:0] next_hop_q;
	logic                   dropped_q;
	logic [rta_pkg::COUNT_W-1:0] count_out_q;

	// Fields of the entry under compare.
	logic [KW-1:0]          ent_dest;
	logic [KW-1:0]          ent_hop;
	logic [LW-1:0]          ent_life;
	logic                   ent_valid;
	logic                   ent_match;
	logic                   tick_expire;
	logic                   tick_age;

	logic                   in_fire;
	logic                   fin_go;
	logic                   learn_new;
	logic                   learn_write;
	logic [CW-1:0]          count_next;
	logic [CWX-1:0]         count_ext;

	logic                   mem_we;
	logic [IW-1:0]          mem_waddr;
	logic [EW-1:0]          mem_wdata;
	logic [IW-1:0]          mem_raddr;

	// A lifetime of zero loads as one, so a fresh entry survives to the next tick.
	assign load_life = (lifetime_q == '0) ? LW'(1) : lifetime_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;

	// The finish step may only load the output register once it is free.
	assign fin_go = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	assign ent_dest  = rd_word_q[EW-1 -: KW];
	assign ent_hop   = rd_word_q[LW +: KW];
	assign ent_life  = rd_word_q[LW-1:0];
	assign ent_valid = valid_q[chk_idx_s1];
	assign ent_match = ent_valid && (ent_dest == key_q);

	assign tick_expire = chk_vld_s1 && (op_q == rta_pkg::OP_TICK) && ent_valid
		&& (ent_life <= LW'(1));
	assign tick_age    = chk_vld_s1 && (op_q == rta_pkg::OP_TICK) && ent_valid
		&& (ent_life > LW'(1));

	// A learn of an unknown destination takes the first free slot, if any.
	assign learn_new   = (op_q == rta_pkg::OP_LEARN) && !found_q && free_q;
	assign learn_write = (op_q == rta_pkg::OP_LEARN) && (found_q || free_q);
	assign count_next  = count_q + CW'(learn_new);
	assign count_ext   = CWX'(count_next);

	assign mem_raddr = idx_q;

	// Single write port: aging write-backs during the walk, learn writes at the finish.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = chk_idx_s1;
		mem_wdata = {ent_dest, ent_hop, ent_life - LW'(1)};
		if (tick_age) begin
			mem_we = 1'b1;
		end else if (fin_go && learn_write) begin
			mem_we = 1'b1;
			if (found_q) begin
				mem_waddr = found_idx_q;
				mem_wdata = {key_q, found_hop_q, load_life};
			end else begin
				mem_waddr = free_idx_q;
				mem_wdata = {key_q, hop_in_q, load_life};
			end
		end
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_word_q <= tbl_mem_q[mem_raddr];
	end

	// Lifetime register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= rta_pkg::LIFETIME_RESET;
		end else if (cfg_we) begin
			lifetime_q <= cfg_wdata;
		end
	end

	// Sequencer: walk every entry, drain the compare stage, then finish the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			chk_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					chk_vld_s1 <= 1'b0;
					idx_q      <= '0;
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= 1'b1;
					if (idx_q == IW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					chk_vld_s1 <= 1'b0;
					state_q    <= ST_FINISH;
				end
				ST_FINISH: begin
					chk_vld_s1 <= 1'b0;
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					chk_vld_s1 <= 1'b0;
					state_q    <= ST_IDLE;
				end
			endcase
		end
	end

	// Item latch, compare stage index and scan results.
	always_ff @(posedge clk) begin
		chk_idx_s1 <= idx_q;
		if (in_fire) begin
			op_q     <= op;
			key_q    <= dest_addr[KW-1:0];
			hop_in_q <= hop_addr[KW-1:0];
			found_q  <= 1'b0;
			free_q   <= 1'b0;
		end else if (chk_vld_s1) begin
			if (ent_match && !found_q) begin
				found_q     <= 1'b1;
				found_idx_q <= chk_idx_s1;
				found_hop_q <= ent_hop;
			end
			if (!ent_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end
		end
	end

	// Valid bits and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (tick_expire) begin
			valid_q[chk_idx_s1] <= 1'b0;
			count_q             <= count_q - CW'(1);
		end else if (fin_go && learn_new) begin
			valid_q[free_idx_q] <= 1'b1;
			count_q             <= count_next;
		end
	end

	// Output register: holds a result beat until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hit_q       <= found_q && ((op_q == rta_pkg::OP_LEARN)
				|| (op_q == rta_pkg::OP_LOOKUP));
			next_hop_q  <= (found_q && (op_q == rta_pkg::OP_LOOKUP))
				? rta_pkg::FIELD_W'(found_hop_q) : '0;
			dropped_q   <= (op_q == rta_pkg::OP_LEARN) && !found_q && !free_q;
			count_out_q <= count_ext[rta_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign next_hop    = next_hop_q;
	assign dropped     = dropped_q;
	assign entry_count = count_out_q;

`ifndef NO_ASSERTIONS
	// The running count always agrees with the valid bits.
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("entry count disagrees with valid bits");

	// The count never exceeds the table depth.
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	// An accepted item always starts a walk.
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

	// The compare stage is only active during the walk and its drain.
	a_compare_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> ((state_q == ST_SCAN) || (state_q == ST_DRAIN)))
		else $error("compare stage active outside the walk");

	// A finish that finds the output register busy waits for it.
	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && out_valid_q && out_stall) |=> (state_q == ST_FINISH))
		else $error("finish step left while output register was busy");
`endif

endmodule
